@@ design/dnp_pkg.sv @@
`timescale 1ns / 1ps

package dnp_pkg;

  // Width of the decimal accumulators; results keep the low 32 bits.
  localparam int NUMBER_WIDTH = 32;
  localparam int OUT_WIDTH    = 32;

  typedef logic [NUMBER_WIDTH-1:0] acc_t;
  typedef logic [OUT_WIDTH-1:0]    num_t;
  typedef logic [7:0]              char_t;
  typedef logic [1:0]              phase_t;
  typedef logic [2:0]              kind_t;

  localparam phase_t PH_PREFIX = 2'd0;
  localparam phase_t PH_CTRL   = 2'd1;
  localparam phase_t PH_PART   = 2'd2;
  localparam phase_t PH_ERROR  = 2'd3;

  localparam int PREFIX_COUNT = 7;
  localparam logic [PREFIX_COUNT-1:0] ALL_LIVE = '1;

  localparam char_t CH_END  = 8'h00;
  localparam char_t CH_DASH = "-";
  localparam char_t CH_ZERO = "0";
  localparam char_t CH_NINE = "9";

  // Prefix text in kind-code order, padded with zero bytes.
  localparam char_t PREFIX_TEXT [PREFIX_COUNT][4] = '{
    '{"n", "v", "m", "e"},
    '{"s", "a", "t", "a"},
    '{"s", "c", "s", "i"},
    '{"i", "d", "e", 8'h00},
    '{"e", "e", "m", "c"},
    '{"u", "s", "b", 8'h00},
    '{"s", "d", 8'h00, 8'h00}
  };

  localparam logic [2:0] PREFIX_LEN [PREFIX_COUNT] = '{
    3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd2
  };

  // acc * 10 + digit, wrapping at the accumulator width.
  function automatic acc_t acc_push(input acc_t acc, input logic [3:0] digit);
    acc_t x8;
    acc_t x2;
    x8 = {acc[NUMBER_WIDTH-4:0], 3'b000};
    x2 = {acc[NUMBER_WIDTH-2:0], 1'b0};
    return x8 + x2 + NUMBER_WIDTH'(digit);
  endfunction

  // Low result bits of an accumulator, zero-extended when it is narrower.
  function automatic num_t acc_to_num(input acc_t acc);
    logic [63:0] wide;
    wide = 64'(acc);
    return wide[OUT_WIDTH-1:0];
  endfunction

endpackage

@@ design/disk_name_parser_core.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Ports                                   Item
// in       input      in_valid, in_ready, in_char_code        one name character
// out      output     out_valid, out_ready, out_name_ok,      one parse result
//                     out_kind_code, out_controller_number,   per zero byte
//                     out_partition_number
//
// Each character goes through an input register, then one combinational pass
// that updates the parse state and, for a zero byte, loads the result register.
// One character per cycle unless a zero byte waits; the result loads as that byte leaves char_r.
// Reset (rst_n low, synchronous) clears both registers' valid flags and the parse state.
// Only a zero byte waits on a full result register, so a stalled output holds
// back the input only when the next character ends a name.
module disk_name_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dnp_pkg::char_t       in_char_code,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_name_ok,
  output dnp_pkg::kind_t       out_kind_code,
  output dnp_pkg::num_t        out_controller_number,
  output dnp_pkg::num_t        out_partition_number
);
  import dnp_pkg::*;

  char_t                   char_r;
  logic                    char_vld_r;
  phase_t                  phase_r,  phase_nxt;
  logic [2:0]              pos_r,    pos_nxt;
  logic [PREFIX_COUNT-1:0] live_r,   live_nxt;
  kind_t                   kind_r,   kind_nxt;
  logic                    seen_r,   seen_nxt;
  acc_t                    ctrl_r,   ctrl_nxt;
  acc_t                    part_r,   part_nxt;

  logic                    out_vld_r;
  logic                    ok_r;
  kind_t                   okind_r;
  num_t                    octrl_r;
  num_t                    opart_r;

  logic                    is_end;
  logic                    is_digit;
  logic [3:0]              digit;
  logic                    proc;
  logic                    ok_now;
  logic [PREFIX_COUNT-1:0] hit_more;
  logic [PREFIX_COUNT-1:0] hit_last;
  logic                    done;
  kind_t                   done_kind;

  assign is_end   = (char_r == CH_END);
  assign is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign digit    = 4'(char_r - CH_ZERO);

  // A zero byte needs room in the result register; other characters never wait.
  assign proc     = char_vld_r && (!is_end || !out_vld_r || out_ready);
  assign in_ready = !char_vld_r || proc;
  assign ok_now   = (phase_r == PH_PART) && seen_r;

  always_comb begin
    hit_more  = '0;
    hit_last  = '0;
    done_kind = '0;
    for (int k = 0; k < PREFIX_COUNT; k++) begin
      if (live_r[k] && (pos_r < PREFIX_LEN[k]) &&
          (PREFIX_TEXT[k][pos_r[1:0]] == char_r)) begin
        if ((pos_r + 3'd1) == PREFIX_LEN[k]) begin
          hit_last[k] = 1'b1;
        end else begin
          hit_more[k] = 1'b1;
        end
      end
    end
    // The lowest kind code wins if two prefixes ever ended together.
    for (int k = PREFIX_COUNT - 1; k >= 0; k--) begin
      if (hit_last[k]) begin
        done_kind = 3'(k);
      end
    end
    done = |hit_last;
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    live_nxt  = live_r;
    kind_nxt  = kind_r;
    seen_nxt  = seen_r;
    ctrl_nxt  = ctrl_r;
    part_nxt  = part_r;
    if (is_end) begin
      phase_nxt = PH_PREFIX;
      pos_nxt   = '0;
      live_nxt  = ALL_LIVE;
      kind_nxt  = '0;
      seen_nxt  = 1'b0;
      ctrl_nxt  = '0;
      part_nxt  = '0;
    end else begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (done) begin
            phase_nxt = PH_CTRL;
            kind_nxt  = done_kind;
            seen_nxt  = 1'b0;
          end else if (hit_more == '0) begin
            phase_nxt = PH_ERROR;
          end else begin
            live_nxt = hit_more;
            pos_nxt  = pos_r + 3'd1;
          end
        end
        PH_CTRL: begin
          if (is_digit) begin
            ctrl_nxt = acc_push(ctrl_r, digit);
            seen_nxt = 1'b1;
          end else if ((char_r == CH_DASH) && seen_r) begin
            phase_nxt = PH_PART;
            seen_nxt  = 1'b0;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        PH_PART: begin
          if (is_digit) begin
            part_nxt = acc_push(part_r, digit);
            seen_nxt = 1'b1;
          end else begin
            phase_nxt = PH_ERROR;
          end
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_vld_r <= 1'b0;
    end else if (in_ready) begin
      char_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      pos_r   <= '0;
      live_r  <= ALL_LIVE;
      kind_r  <= '0;
      seen_r  <= 1'b0;
      ctrl_r  <= '0;
      part_r  <= '0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      live_r  <= live_nxt;
      kind_r  <= kind_nxt;
      seen_r  <= seen_nxt;
      ctrl_r  <= ctrl_nxt;
      part_r  <= part_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && is_end) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_end) begin
      ok_r    <= ok_now;
      okind_r <= ok_now ? kind_r : '0;
      octrl_r <= ok_now ? acc_to_num(ctrl_r) : '0;
      opart_r <= ok_now ? acc_to_num(part_r) : '0;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_name_ok           = ok_r;
  assign out_kind_code         = okind_r;
  assign out_controller_number = octrl_r;
  assign out_partition_number  = opart_r;

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && is_end) |=> out_vld_r)
    else $error("zero byte did not load a result");

  a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && is_end) |=> (phase_r == PH_PREFIX) && (live_r == ALL_LIVE) &&
                         (pos_r == 3'd0) && !seen_r)
    else $error("parse state not cleared after a name");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !ok_r) |-> (okind_r == '0) && (octrl_r == '0) && (opart_r == '0))
    else $error("invalid result carries nonzero fields");

  a_stall_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (char_vld_r && is_end && out_vld_r && !out_ready))
    else $error("input held back without a pending zero byte");

endmodule

@@ verif/disk_name_parser_checker.sv @@
`timescale 1ns / 1ps

module disk_name_parser_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  dnp_pkg::char_t in_char_code,
  input  logic           out_valid,
  input  logic           out_ready,
  input  logic           out_name_ok,
  input  dnp_pkg::kind_t out_kind_code,
  input  dnp_pkg::num_t  out_controller_number,
  input  dnp_pkg::num_t  out_partition_number,
  output int             fail_count,
  output int             pending,
  output int             names_checked,
  output int             names_ok
);

  import dnp_pkg::*;

  typedef struct packed {
    logic  ok;
    kind_t kind;
    num_t  ctrl;
    num_t  part;
  } parse_result_t;

  parse_result_t result_q[$];

  // Shadow copy of the parse state.
  phase_t                  phase;
  logic [2:0]              pos;
  logic [PREFIX_COUNT-1:0] live;
  kind_t                   kind;
  logic                    seen;
  acc_t                    ctrl_acc;
  acc_t                    part_acc;

  task automatic clear_parse();
    phase    = PH_PREFIX;
    pos      = '0;
    live     = ALL_LIVE;
    kind     = '0;
    seen     = 1'b0;
    ctrl_acc = '0;
    part_acc = '0;
  endtask

  task automatic parse_char(input char_t c);
    logic [PREFIX_COUNT-1:0] next;
    logic                    done;
    logic                    is_digit;
    parse_result_t           res;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (c == CH_END) begin
      res.ok   = (phase == PH_PART) && seen;
      res.kind = res.ok ? kind : '0;
      res.ctrl = res.ok ? num_t'(ctrl_acc) : '0;
      res.part = res.ok ? num_t'(part_acc) : '0;
      result_q.push_back(res);
      clear_parse();
    end else begin
      case (phase)
        PH_PREFIX: begin
          next = '0;
          done = 1'b0;
          for (int k = 0; k < PREFIX_COUNT; k++) begin
            if (live[k] && int'(pos) < int'(PREFIX_LEN[k])) begin
              if (PREFIX_TEXT[k][pos[1:0]] == c) begin
                if (int'(pos) + 1 == int'(PREFIX_LEN[k])) begin
                  if (!done) begin
                    done = 1'b1;
                    kind = kind_t'(k);
                  end
                end else begin
                  next[k] = 1'b1;
                end
              end
            end
          end
          if (done) begin
            phase = PH_CTRL;
            seen  = 1'b0;
          end else if (next == '0) begin
            phase = PH_ERROR;
          end else begin
            live = next;
            pos  = pos + 3'd1;
          end
        end
        PH_CTRL: begin
          if (is_digit) begin
            ctrl_acc = acc_t'(ctrl_acc * 10 + acc_t'(c - CH_ZERO));
            seen     = 1'b1;
          end else if (c == CH_DASH && seen) begin
            phase = PH_PART;
            seen  = 1'b0;
          end else begin
            phase = PH_ERROR;
          end
        end
        PH_PART: begin
          if (is_digit) begin
            part_acc = acc_t'(part_acc * 10 + acc_t'(c - CH_ZERO));
            seen     = 1'b1;
          end else begin
            phase = PH_ERROR;
          end
        end
        default: phase = PH_ERROR;
      endcase
    end
  endtask

  initial begin
    fail_count    = 0;
    pending       = 0;
    names_checked = 0;
    names_ok      = 0;
    clear_parse();
  end

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      clear_parse();
      result_q.delete();
    end else begin
      // The result side is handled first so that a result never meets the
      // expectation of the item taken in the same cycle.
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          want = result_q.pop_front();
          names_checked++;
          if (want.ok) names_ok++;
          if (out_name_ok !== want.ok) begin
            $error("name_ok: expected %0d, got %0d", want.ok, out_name_ok);
            fail_count++;
          end
          if (out_kind_code !== want.kind) begin
            $error("kind_code: expected %0d, got %0d", want.kind, out_kind_code);
            fail_count++;
          end
          if (out_controller_number !== want.ctrl) begin
            $error("controller_number: expected %0d, got %0d",
                   want.ctrl, out_controller_number);
            fail_count++;
          end
          if (out_partition_number !== want.part) begin
            $error("partition_number: expected %0d, got %0d",
                   want.part, out_partition_number);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) parse_char(in_char_code);
    end
    pending = result_q.size();
  end

endmodule

@@ verif/disk_name_parser_core_tb.sv @@
`timescale 1ns / 1ps

module disk_name_parser_core_tb;

  import dnp_pkg::*;

  localparam int CHAR_TARGET  = 1950;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_START   = 300;
  localparam int HOLD_CYCLES  = 400;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  char_t in_char_code;
  logic  out_valid;
  logic  out_ready;
  logic  out_name_ok;
  kind_t out_kind_code;
  num_t  out_controller_number;
  num_t  out_partition_number;

  int fail_count;
  int pending;
  int names_checked;
  int names_ok;

  char_t char_stream[$];
  char_t name_buf[$];
  logic  calm;
  int    idle_cycles;

  disk_name_parser_core dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_char_code          (in_char_code),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_name_ok           (out_name_ok),
    .out_kind_code         (out_kind_code),
    .out_controller_number (out_controller_number),
    .out_partition_number  (out_partition_number)
  );

  disk_name_parser_checker checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_char_code          (in_char_code),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_name_ok           (out_name_ok),
    .out_kind_code         (out_kind_code),
    .out_controller_number (out_controller_number),
    .out_partition_number  (out_partition_number),
    .fail_count            (fail_count),
    .pending               (pending),
    .names_checked         (names_checked),
    .names_ok              (names_ok)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic add_text(input string s);
    for (int j = 0; j < s.len(); j++) char_stream.push_back(char_t'(s[j]));
  endtask

  task automatic add_digits();
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
    repeat (n) name_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
  endtask

  task automatic add_good_name();
    int k;
    k = $urandom_range(0, PREFIX_COUNT - 1);
    for (int j = 0; j < int'(PREFIX_LEN[k]); j++) name_buf.push_back(PREFIX_TEXT[k][j]);
    add_digits();
    name_buf.push_back(CH_DASH);
    add_digits();
  endtask

  task automatic build_stimulus();
    int sel;
    int cut;
    // Directed names: shortest good name, empty name, missing controller
    // digits, missing partition digits, a stray high byte, and an early end.
    add_text("sd0-9");
    char_stream.push_back(CH_END);
    char_stream.push_back(CH_END);
    add_text("ide-1");
    char_stream.push_back(CH_END);
    add_text("usb1-");
    char_stream.push_back(CH_END);
    add_text("sd");
    char_stream.push_back(8'hFF);
    char_stream.push_back(CH_END);
    add_text("sd1");
    char_stream.push_back(CH_END);
    // Mostly well-formed names with random content, some broken ones.
    while (char_stream.size() < CHAR_TARGET) begin
      name_buf.delete();
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        add_good_name();
      end else if (sel == 7) begin
        add_good_name();
        name_buf[$urandom_range(0, name_buf.size() - 1)] = char_t'($urandom_range(1, 255));
      end else if (sel == 8) begin
        add_good_name();
        cut = $urandom_range(0, name_buf.size() - 1);
        while (name_buf.size() > cut) void'(name_buf.pop_back());
      end else begin
        repeat ($urandom_range(0, 6)) name_buf.push_back(char_t'($urandom_range(1, 255)));
      end
      foreach (name_buf[j]) char_stream.push_back(name_buf[j]);
      char_stream.push_back(CH_END);
    end
  endtask

  // Sender and verdict.
  initial begin
    int calm_from;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = CH_END;
    calm         = 1'b0;
    build_stimulus();
    calm_from = char_stream.size() * 85 / 100;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int i = 0; i < char_stream.size(); i++) begin
      if (i >= calm_from) calm = 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      in_valid     = 1'b1;
      in_char_code = char_stream[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d characters; checked %0d names, %0d of them well formed.",
             char_stream.size(), names_checked, names_ok);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver: short random stalls, one long hold-off, none in the tail.
  initial begin
    int cycle;
    int stall_left;
    int hold_left;
    out_ready  = 1'b0;
    cycle      = 0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (rst_n) begin
        cycle++;
        if (cycle == HOLD_START) hold_left = HOLD_CYCLES;
        if (hold_left > 0) begin
          hold_left--;
          out_ready = 1'b0;
        end else if (calm) begin
          out_ready = 1'b1;
        end else if (stall_left > 0) begin
          stall_left--;
          out_ready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 9) - 1;
          out_ready  = 1'b0;
        end else begin
          out_ready = 1'b1;
        end
      end
    end
  end

  // Ends the run when neither channel moves an item for too long.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

@@ disk_name_parser_core.f @@
design/dnp_pkg.sv
design/disk_name_parser_core.sv
verif/disk_name_parser_checker.sv
verif/disk_name_parser_core_tb.sv
